@@ hdl/shs_pkg.sv @@
// ============================================================================
// shs_pkg: shared types, constants and functions of the SHA-256 stream hasher
// Holds the beat types, operation codes, the initial vector and the
// round-constant table used by the front, back and round datapath.
// ============================================================================
package shs_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] hv_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam int QUEUE_DEPTH = 4;

  // Word 0 sits in element 0 of the packed array.
  localparam hv_t INIT_VEC = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                              32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/sha256_stream_hasher_unit.sv @@
// ============================================================================
// sha256_stream_hasher_unit: byte-stream SHA-256 engine
// Absorbs message bytes, and on finish or peek emits the eight digest words.
// ============================================================================
//
//   Channel | Direction | Beat payload                           | Handshake
//   --------+-----------+----------------------------------------+-------------
//   in_     | input     | in_item  (operation, data_byte)        | valid/stall
//   out_    | output    | out_item (digest_word, word_index,     | valid/stall
//           |           |           last_word)                   |
//
// An absorb beat is taken by the back end while it is idle, and the beat that
// completes a 64-byte block also runs 64 rounds through the single shared
// round datapath and then folds the result into the chaining words. A
// finish or peek beat leaves the queue and is padded serially byte by byte
// to the end of the block; when the length no longer fits in the current
// block, that block is compressed and a further one is padded. The final
// compression follows, then the emission of the eight words, which waits
// while the output side is stalled.
// Reset is synchronous and active low; it restores the initial vector and
// empties the queue. The input queue keeps accepting beats while the back
// end compresses or waits on a stalled result, and stalls only when full.
//
module sha256_stream_hasher_unit #(
  parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  shs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output shs_pkg::out_item_t out_item
);

  // Link between the front queue and the back end.
  logic              q_valid;
  logic              q_take;
  shs_pkg::in_item_t q_item;

  // The front classifies beats: the unused operation code is dropped here,
  // so the back end only ever sees absorb, finish and peek.
  shs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  // The back end collects bytes, pads a shadow copy of the state for a
  // digest and drives the output register.
  shs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ hdl/shs_front.sv @@
// ============================================================================
// shs_front: input acceptance and item queue
// Accepts beats, drops the unused operation code and buffers the rest in a
// short queue that the back end drains at its own pace.
// ============================================================================
module shs_front #(
  parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  shs_pkg::in_item_t in_item,
  output logic             q_valid,
  output shs_pkg::in_item_t q_item,
  input  logic             q_take
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  shs_pkg::in_item_t mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_stall = (cnt_r == CntW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && (in_item.operation != shs_pkg::OP_UNUSED);
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

@@ hdl/shs_round.sv @@
// ============================================================================
// shs_round: one SHA-256 round and one schedule expansion step
// Combinational datapath between the working-variable and schedule registers.
// ============================================================================
module shs_round (
  input  shs_pkg::hv_t   v,
  input  logic [511:0]   sch,
  input  shs_pkg::word_t k,
  output shs_pkg::hv_t   v_out,
  output shs_pkg::word_t w_new
);

  function automatic shs_pkg::word_t rotr(input shs_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  shs_pkg::word_t w0, w1, w9, w14, s0, s1, bs0, bs1, ch, maj, t1, t2;

  always_comb begin
    w0  = sch[511:480];
    w1  = sch[479:448];
    w9  = sch[223:192];
    w14 = sch[63:32];
    s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = w0 + s0 + w9 + s1;

    bs1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + bs1 + ch + k + w0;
    bs0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = bs0 + maj;

    v_out[7] = v[6];
    v_out[6] = v[5];
    v_out[5] = v[4];
    v_out[4] = v[3] + t1;
    v_out[3] = v[2];
    v_out[2] = v[1];
    v_out[1] = v[0];
    v_out[0] = t1 + t2;
  end

endmodule

@@ hdl/shs_back.sv @@
// ============================================================================
// shs_back: block collection, padding, compression and digest emission
// Carries out one queued operation at a time with a shared round datapath.
// ============================================================================
module shs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  shs_pkg::in_item_t q_item,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_stall,
  output shs_pkg::out_item_t out_item
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]   state_r, state_nxt, ret_r, ret_nxt;
  shs_pkg::hv_t chain_r, chain_nxt, dig_r, dig_nxt, v_r, v_nxt, v_rnd;
  logic [511:0] sch_r, sch_nxt, blk_r, blk_nxt;
  logic [5:0]   fill_r, fill_nxt, pos_r, pos_nxt, rnd_r, rnd_nxt;
  logic [63:0]  msg_r, msg_nxt, len_r, len_nxt;
  logic         mark_r, mark_nxt, xtra_r, xtra_nxt, dsel_r, dsel_nxt;
  logic [2:0]   emi_r, emi_nxt;
  logic         out_valid_r, out_valid_nxt;
  shs_pkg::out_item_t out_item_r, out_item_nxt;
  shs_pkg::word_t w_new;
  logic         ld, xtra_eff;
  logic [7:0]   pad_byte;

  shs_round u_round (
    .v     (v_r),
    .sch   (sch_r),
    .k     (shs_pkg::round_k(rnd_r)),
    .v_out (v_rnd),
    .w_new (w_new)
  );

  assign q_take    = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign ld        = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;
    chain_nxt = chain_r;  dig_nxt = dig_r;  v_nxt = v_r;
    sch_nxt = sch_r;  blk_nxt = blk_r;
    fill_nxt = fill_r;  pos_nxt = pos_r;  rnd_nxt = rnd_r;
    msg_nxt = msg_r;  len_nxt = len_r;
    mark_nxt = mark_r;  xtra_nxt = xtra_r;  dsel_nxt = dsel_r;
    emi_nxt = emi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    xtra_eff = mark_r ? xtra_r : (pos_r >= shs_pkg::LEN_POS);
    if (!mark_r) begin
      pad_byte = shs_pkg::PAD_MARK;
    end else if (xtra_r || pos_r < shs_pkg::LEN_POS) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_r[63:56];
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.operation == shs_pkg::OP_ABSORB) begin
            blk_nxt  = {blk_r[503:0], q_item.data_byte};
            msg_nxt  = msg_r + 64'd1;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              sch_nxt   = {blk_r[503:0], q_item.data_byte};
              v_nxt     = chain_r;
              dsel_nxt  = 1'b0;
              rnd_nxt   = '0;
              ret_nxt   = S_IDLE;
              state_nxt = S_COMP;
            end
          end else begin
            dig_nxt   = chain_r;
            sch_nxt   = blk_r;
            pos_nxt   = fill_r;
            len_nxt   = {msg_r[60:0], 3'b000};
            mark_nxt  = 1'b0;
            xtra_nxt  = 1'b0;
            state_nxt = S_PAD;
            if (q_item.operation == shs_pkg::OP_FINISH) begin
              chain_nxt = shs_pkg::INIT_VEC;
              fill_nxt  = '0;
              msg_nxt   = '0;
            end
          end
        end
      end
      S_PAD: begin
        sch_nxt  = {sch_r[503:0], pad_byte};
        pos_nxt  = pos_r + 6'd1;
        mark_nxt = 1'b1;
        xtra_nxt = xtra_eff;
        if (mark_r && !xtra_r && pos_r >= shs_pkg::LEN_POS) begin
          len_nxt = {len_r[55:0], 8'h00};
        end
        if (pos_r == 6'd63) begin
          v_nxt     = dig_r;
          dsel_nxt  = 1'b1;
          rnd_nxt   = '0;
          xtra_nxt  = 1'b0;
          ret_nxt   = xtra_eff ? S_PAD : S_EMIT;
          emi_nxt   = '0;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        v_nxt   = v_rnd;
        sch_nxt = {sch_r[479:0], w_new};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          if (dsel_r) begin
            dig_nxt[i] = dig_r[i] + v_r[i];
          end else begin
            chain_nxt[i] = chain_r[i] + v_r[i];
          end
        end
        state_nxt = ret_r;
      end
      S_EMIT: begin
        if (ld) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.digest_word = dig_r[emi_r];
          out_item_nxt.word_index  = emi_r;
          out_item_nxt.last_word   = (emi_r == 3'd7);
          emi_nxt                  = emi_r + 3'd1;
          if (emi_r == 3'd7) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      chain_r     <= shs_pkg::INIT_VEC;
      fill_r      <= '0;
      msg_r       <= '0;
      pos_r       <= '0;
      rnd_r       <= '0;
      mark_r      <= 1'b0;
      xtra_r      <= 1'b0;
      dsel_r      <= 1'b0;
      emi_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      chain_r     <= chain_nxt;
      fill_r      <= fill_nxt;
      msg_r       <= msg_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      mark_r      <= mark_nxt;
      xtra_r      <= xtra_nxt;
      dsel_r      <= dsel_nxt;
      emi_r       <= emi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    v_r        <= v_nxt;
    sch_r      <= sch_nxt;
    blk_r      <= blk_nxt;
    len_r      <= len_nxt;
    out_item_r <= out_item_nxt;
  end

  // The final padded block always ends exactly on a block boundary.
  a_emit_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (pos_r == 6'd0))
    else $error("digest emission started off a block boundary");

  // A message block is only compressed once all 64 bytes have been collected.
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && rnd_r == 6'd0 && !dsel_r) |-> (fill_r == 6'd0))
    else $error("message compression started on a partial block");

  // Loading the eighth word ends the digest and frees the back end.
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && ld && emi_r == 3'd7) |=> (state_r == S_IDLE && out_valid_r))
    else $error("digest emission did not complete after the last word");

endmodule
